FILE: hw/rtl/sqnt_pkg.sv
// Shared types and constants for the symmetric int8 quantizer.
// Used by sqnt_fdiv, sqnt_cvt and symmetric_int8_quantizer; no dependencies.
`default_nettype none
package sqnt_pkg;

  typedef logic [31:0] fp32_t;

  localparam fp32_t FP_ZERO    = 32'h0000_0000;
  localparam fp32_t FP_ONE     = 32'h3F80_0000;
  localparam fp32_t FP_127     = 32'h42FE_0000;
  localparam fp32_t FP_INF     = 32'h7F80_0000;
  localparam fp32_t FP_QNAN    = 32'h7FC0_0000;
  localparam fp32_t FP_MAGMASK = 32'h7FFF_FFFF;

  localparam logic [7:0] EXP_MAX = 8'hFF;

  localparam logic OP_MEASURE  = 1'b0;
  localparam logic OP_QUANTIZE = 1'b1;

  localparam logic KIND_SCALE = 1'b0;
  localparam logic KIND_ELEM  = 1'b1;

endpackage
`default_nettype wire

FILE: hw/rtl/symmetric_int8_quantizer.sv
// Two-pass symmetric absmax FP32 to int8 quantizer, top level.
// Measure items that are not last only update the peak. For a last measure item or a quantize
// item the result comes from the divider; the next item can follow once it is loaded into the
// output register. Subnormal operands or quotients add shift steps in the shared divider,
// which produces one quotient bit a cycle. A finished result waits in the output register
// while the next item is accepted. Synchronous reset: peak +0.0, scale 1.0, no result pending.
`default_nettype none
module symmetric_int8_quantizer (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               in_op,
  input  wire [31:0]        in_value_bits,
  input  wire               in_last,
  output logic              out_valid,
  input  wire               out_ready,
  output logic              out_kind,
  output logic [31:0]       out_scale_bits,
  output logic signed [7:0] out_quantized
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]       state_r, state_nxt;
  sqnt_pkg::fp32_t  peak_r, peak_nxt;
  sqnt_pkg::fp32_t  scale_r, scale_nxt;
  logic             kind_r, kind_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic             okind_r, okind_nxt;
  logic [31:0]      oscale_r, oscale_nxt;
  logic signed [7:0] oq_r, oq_nxt;

  logic             accept, start, out_free, load;
  sqnt_pkg::fp32_t  mag, peak_upd, div_a, div_b, div_q, new_scale;
  logic             div_done;
  logic signed [7:0] q8;

  sqnt_fdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  sqnt_cvt u_cvt (
    .value  (div_q),
    .result (q8)
  );

  always_comb begin
    in_ready = (state_r == S_IDLE);
    accept   = in_valid && in_ready;
    mag      = in_value_bits & sqnt_pkg::FP_MAGMASK;
    // A NaN magnitude never wins the compare.
    peak_upd = ((mag <= sqnt_pkg::FP_INF) && (mag > peak_r)) ? mag : peak_r;
    start    = accept && ((in_op == sqnt_pkg::OP_QUANTIZE) || in_last);
    div_a    = (in_op == sqnt_pkg::OP_QUANTIZE) ? in_value_bits : peak_upd;
    div_b    = (in_op == sqnt_pkg::OP_QUANTIZE) ? scale_r : sqnt_pkg::FP_127;
    new_scale = (div_q == sqnt_pkg::FP_ZERO) ? sqnt_pkg::FP_ONE : div_q;

    out_free = !ovalid_r || out_ready;
    load     = ((state_r == S_DIV && div_done) || state_r == S_HOLD) && out_free;

    state_nxt  = state_r;
    peak_nxt   = peak_r;
    scale_nxt  = scale_r;
    kind_nxt   = kind_r;
    ovalid_nxt = ovalid_r;
    okind_nxt  = okind_r;
    oscale_nxt = oscale_r;
    oq_nxt     = oq_r;

    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_op == sqnt_pkg::OP_MEASURE) begin
          peak_nxt = in_last ? sqnt_pkg::FP_ZERO : peak_upd;
        end
        if (start) begin
          kind_nxt  = (in_op == sqnt_pkg::OP_QUANTIZE) ? sqnt_pkg::KIND_ELEM
                                                       : sqnt_pkg::KIND_SCALE;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = load ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load) begin
      ovalid_nxt = 1'b1;
      okind_nxt  = kind_r;
      if (kind_r == sqnt_pkg::KIND_SCALE) begin
        scale_nxt  = new_scale;
        oscale_nxt = new_scale;
        oq_nxt     = 8'sd0;
      end else begin
        oscale_nxt = scale_r;
        oq_nxt     = q8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      peak_r   <= sqnt_pkg::FP_ZERO;
      scale_r  <= sqnt_pkg::FP_ONE;
      kind_r   <= sqnt_pkg::KIND_SCALE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      peak_r   <= peak_nxt;
      scale_r  <= scale_nxt;
      kind_r   <= kind_nxt;
      ovalid_r <= ovalid_nxt;
    end
    okind_r  <= okind_nxt;
    oscale_r <= oscale_nxt;
    oq_r     <= oq_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_kind       = okind_r;
  assign out_scale_bits = oscale_r;
  assign out_quantized  = oq_r;

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input taken while an item is in the divider");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished with no item in flight");

  a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    scale_r != sqnt_pkg::FP_ZERO && !scale_r[31])
    else $error("held scale is zero or negative");

  a_peak_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r <= sqnt_pkg::FP_INF)
    else $error("peak holds a NaN or a negative value");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/sqnt_fdiv.sv
// Iterative IEEE single divider, round to nearest even, with subnormals.
// One restoring step per cycle; depends on sqnt_pkg.
`default_nettype none
module sqnt_fdiv (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  input  sqnt_pkg::fp32_t dividend,
  input  sqnt_pkg::fp32_t divisor,
  output logic            done,
  output sqnt_pkg::fp32_t quotient
);

  localparam logic [2:0] D_IDLE   = 3'd0;
  localparam logic [2:0] D_NORM   = 3'd1;
  localparam logic [2:0] D_DIV    = 3'd2;
  localparam logic [2:0] D_DENORM = 3'd3;
  localparam logic [2:0] D_ROUND  = 3'd4;

  localparam logic [4:0] LAST_STEP = 5'd26;

  logic [2:0]        state_r, state_nxt;
  logic              done_r, done_nxt;
  logic [23:0]       ma_r, ma_nxt, mb_r, mb_nxt;
  logic [24:0]       rem_r, rem_nxt;
  logic [26:0]       quo_r, quo_nxt;
  logic signed [9:0] exp_r, exp_nxt;
  logic              sign_r, sign_nxt;
  logic              sticky_r, sticky_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  sqnt_pkg::fp32_t   res_r, res_nxt;

  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [24:0] diff;
  logic        qbit;
  logic [24:0] msum;
  logic [23:0] mrnd;
  logic signed [9:0] erend;
  logic        rnd_up;

  always_comb begin
    ea = dividend[30:23];
    eb = divisor[30:23];
    fa = dividend[22:0];
    fb = divisor[22:0];
    nan_a  = (ea == sqnt_pkg::EXP_MAX) && (fa != 23'd0);
    nan_b  = (eb == sqnt_pkg::EXP_MAX) && (fb != 23'd0);
    inf_a  = (ea == sqnt_pkg::EXP_MAX) && (fa == 23'd0);
    inf_b  = (eb == sqnt_pkg::EXP_MAX) && (fb == 23'd0);
    zero_a = (ea == 8'd0) && (fa == 23'd0);
    zero_b = (eb == 8'd0) && (fb == 23'd0);

    diff = rem_r - {1'b0, mb_r};
    qbit = (rem_r >= {1'b0, mb_r});

    rnd_up = quo_r[2] & ((|quo_r[1:0]) | sticky_r | quo_r[3]);
    msum   = {1'b0, quo_r[26:3]} + {24'd0, rnd_up};
    if (msum[24]) begin
      mrnd  = msum[24:1];
      erend = exp_r + 10'sd1;
    end else begin
      mrnd  = msum[23:0];
      erend = exp_r;
    end

    state_nxt  = state_r;
    done_nxt   = 1'b0;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    exp_nxt    = exp_r;
    sign_nxt   = sign_r;
    sticky_nxt = sticky_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;

    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          sign_nxt = dividend[31] ^ divisor[31];
          ma_nxt   = {(ea != 8'd0), fa};
          mb_nxt   = {(eb != 8'd0), fb};
          exp_nxt  = $signed({2'b00, (ea == 8'd0) ? 8'd1 : ea})
                   - $signed({2'b00, (eb == 8'd0) ? 8'd1 : eb}) + 10'sd127;
          if (nan_a || nan_b || (inf_a && inf_b) || (zero_a && zero_b)) begin
            res_nxt  = sqnt_pkg::FP_QNAN;
            done_nxt = 1'b1;
          end else if (inf_a || zero_b) begin
            res_nxt  = {dividend[31] ^ divisor[31], sqnt_pkg::FP_INF[30:0]};
            done_nxt = 1'b1;
          end else if (zero_a || inf_b) begin
            res_nxt  = {dividend[31] ^ divisor[31], 31'd0};
            done_nxt = 1'b1;
          end else begin
            state_nxt = D_NORM;
          end
        end
      end
      D_NORM: begin
        // Subnormal operands are brought up one bit a cycle.
        if (!ma_r[23] || !mb_r[23]) begin
          if (!ma_r[23]) ma_nxt = {ma_r[22:0], 1'b0};
          if (!mb_r[23]) mb_nxt = {mb_r[22:0], 1'b0};
          exp_nxt = exp_r - (ma_r[23] ? 10'sd0 : 10'sd1) + (mb_r[23] ? 10'sd0 : 10'sd1);
        end else begin
          // Keep the quotient in [1, 2) so its leading bit is always set.
          if (ma_r < mb_r) begin
            rem_nxt = {ma_r, 1'b0};
            exp_nxt = exp_r - 10'sd1;
          end else begin
            rem_nxt = {1'b0, ma_r};
          end
          quo_nxt   = 27'd0;
          cnt_nxt   = 5'd0;
          state_nxt = D_DIV;
        end
      end
      D_DIV: begin
        rem_nxt = qbit ? {diff[23:0], 1'b0} : {rem_r[23:0], 1'b0};
        quo_nxt = {quo_r[25:0], qbit};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          sticky_nxt = (rem_nxt != 25'd0);
          state_nxt  = D_DENORM;
        end
      end
      D_DENORM: begin
        if (exp_r < -10'sd25) begin
          quo_nxt    = 27'd0;
          sticky_nxt = 1'b1;
          exp_nxt    = 10'sd1;
        end else if (exp_r < 10'sd1) begin
          quo_nxt    = {1'b0, quo_r[26:1]};
          sticky_nxt = sticky_r | quo_r[0];
          exp_nxt    = exp_r + 10'sd1;
        end else begin
          state_nxt = D_ROUND;
        end
      end
      D_ROUND: begin
        if (erend >= 10'sd255) begin
          res_nxt = {sign_r, sqnt_pkg::FP_INF[30:0]};
        end else begin
          res_nxt = {sign_r, mrnd[23] ? erend[7:0] : 8'd0, mrnd[22:0]};
        end
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    exp_r    <= exp_nxt;
    sign_r   <= sign_nxt;
    sticky_r <= sticky_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
  end

  assign done     = done_r;
  assign quotient = res_r;

endmodule
`default_nettype wire

FILE: hw/rtl/sqnt_cvt.sv
// Single to int8 conversion: round half away from zero, then saturate.
// A NaN gives -128. Depends on sqnt_pkg.
`default_nettype none
module sqnt_cvt (
  input  sqnt_pkg::fp32_t  value,
  output logic signed [7:0] result
);

  logic [7:0]  e;
  logic        is_nan, is_big, is_small;
  logic [23:0] mant;
  logic [7:0]  sdist;
  logic [4:0]  sh;
  logic [23:0] ipart, hpart;
  logic [8:0]  mag;

  always_comb begin
    e        = value[30:23];
    is_nan   = (e == sqnt_pkg::EXP_MAX) && (value[22:0] != 23'd0);
    is_big   = (e >= 8'd134);
    is_small = (e < 8'd126);
    mant     = {1'b1, value[22:0]};
    sdist    = 8'd150 - e;
    sh       = sdist[4:0];
    ipart    = mant >> sh;
    hpart    = mant >> (sh - 5'd1);
    mag      = {1'b0, ipart[7:0]} + {8'd0, hpart[0]};

    if (is_nan) begin
      result = -8'sd128;
    end else if (is_big) begin
      result = value[31] ? -8'sd128 : 8'sd127;
    end else if (is_small) begin
      result = 8'sd0;
    end else if (!value[31]) begin
      result = (mag > 9'd127) ? 8'sd127 : $signed(mag[7:0]);
    end else begin
      result = $signed(8'd0 - mag[7:0]);
    end
  end

endmodule
`default_nettype wire
